// File: rtl/jmsc_pkg.sv
// Shared types, byte codes and constants of the JPEG marker structure checker.
`default_nettype none

package jmsc_pkg;

   // Widths and reset values.
   localparam int BYTE_COUNT_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT      = 4;
   localparam int BUDGET_WIDTH             = 32;
   localparam logic [BUDGET_WIDTH-1:0] BUDGET_RESET = 32'd67108864;

   // Item kinds.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Verdict codes.
   localparam logic VERDICT_ACCEPT = 1'b0;
   localparam logic VERDICT_REJECT = 1'b1;

   // Marker byte codes.
   localparam logic [7:0] CODE_FILL      = 8'hFF;
   localparam logic [7:0] CODE_ZERO      = 8'h00;
   localparam logic [7:0] CODE_SOI       = 8'hD8;
   localparam logic [7:0] CODE_EOI       = 8'hD9;
   localparam logic [7:0] CODE_SOS       = 8'hDA;
   localparam logic [7:0] CODE_SOF_FIRST = 8'hC0;
   localparam logic [7:0] CODE_SOF_LAST  = 8'hCF;
   localparam logic [7:0] CODE_DHT       = 8'hC4;
   localparam logic [7:0] CODE_JPG       = 8'hC8;
   localparam logic [7:0] CODE_DAC       = 8'hCC;
   localparam logic [7:0] CODE_RST_FIRST = 8'hD0;
   localparam logic [7:0] CODE_RST_LAST  = 8'hD7;
   localparam logic [7:0] CODE_TEM       = 8'h01;

   // Segment length limits.
   localparam logic [15:0] MIN_SEG_LEN = 16'd2;
   localparam logic [15:0] MIN_SOF_LEN = 16'd8;
   localparam logic [2:0]  HDR_LAST    = 3'd5;

   // Classes that the front end assigns to every byte.
   typedef enum logic [3:0] {
      BC_FILL,
      BC_ZERO,
      BC_SOI,
      BC_EOI,
      BC_SOS,
      BC_RST,
      BC_TEM,
      BC_SOF,
      BC_OTHER
   } byte_class_type;

   // Parser phases.
   typedef enum logic [3:0] {
      PH_SOI0,
      PH_SOI1,
      PH_PREFIX,
      PH_MARKER,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_SOF_LEN_HI,
      PH_SOF_LEN_LO,
      PH_SOF_HDR,
      PH_SKIP,
      PH_ENTROPY,
      PH_ENTROPY_FF,
      PH_EOI_TAIL,
      PH_ACCEPTED
   } parse_phase_type;

   // One classified item as it sits in the queue.
   typedef struct packed {
      logic           kind;
      logic [7:0]     data_byte;
      byte_class_type byte_class;
   } queue_item_type;

   // Head of the queue as the back end sees it.
   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

endpackage : jmsc_pkg

`default_nettype wire

// File: rtl/jmsc_if.sv
// Channel interfaces of the checker: byte input, result output and budget write.
`default_nettype none

interface jmsc_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface : jmsc_req_if

interface jmsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        verdict;
   logic [15:0] image_width;
   logic [15:0] image_height;

   modport source (output valid, output verdict, output image_width, output image_height,
                   input ready);
   modport sink   (input valid, input verdict, input image_width, input image_height,
                   output ready);
endinterface : jmsc_rsp_if

interface jmsc_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface : jmsc_csr_if

`default_nettype wire

// File: rtl/jmsc_front.sv
// Front end: accepts input transactions and classifies each byte by marker code.
`default_nettype none

module jmsc_front (
   jmsc_req_if.sink          req_bus,
   input  logic              push_ready,
   output logic              push_valid,
   output jmsc_pkg::queue_item_type push_item
);
   import jmsc_pkg::*;

   byte_class_type byte_class;

   // Decode the byte into its marker class.
   always_comb begin
      unique case (req_bus.data_byte) inside
         CODE_FILL:                       byte_class = BC_FILL;
         CODE_ZERO:                       byte_class = BC_ZERO;
         CODE_SOI:                        byte_class = BC_SOI;
         CODE_EOI:                        byte_class = BC_EOI;
         CODE_SOS:                        byte_class = BC_SOS;
         CODE_TEM:                        byte_class = BC_TEM;
         [CODE_RST_FIRST:CODE_RST_LAST]:  byte_class = BC_RST;
         CODE_DHT, CODE_JPG, CODE_DAC:    byte_class = BC_OTHER;
         [CODE_SOF_FIRST:CODE_DHT - 8'd1],
         [CODE_DHT + 8'd1:CODE_JPG - 8'd1],
         [CODE_JPG + 8'd1:CODE_DAC - 8'd1],
         [CODE_DAC + 8'd1:CODE_SOF_LAST]: byte_class = BC_SOF;
         default:                         byte_class = BC_OTHER;
      endcase
   end

   // A transaction is taken whenever the queue has room.
   assign req_bus.ready        = push_ready;
   assign push_valid           = req_bus.valid;
   assign push_item.kind       = req_bus.kind;
   assign push_item.data_byte  = req_bus.data_byte;
   assign push_item.byte_class = byte_class;

endmodule : jmsc_front

`default_nettype wire

// File: rtl/jmsc_queue.sv
// Short register queue between the classifying front end and the parser.
`default_nettype none

module jmsc_queue #(
   parameter int QUEUE_DEPTH = jmsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  jmsc_pkg::queue_item_type push_item,
   output logic                     push_ready,
   input  logic                     pop,
   output jmsc_pkg::queue_head_type head
);
   import jmsc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   queue_item_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign push_ready = (count_ff != CNT_FULL);
   assign push       = push_valid && push_ready;
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule : jmsc_queue

`default_nettype wire

// File: rtl/jmsc_back.sv
// Back end: marker segment parser with byte budget and the result register.
`default_nettype none

module jmsc_back #(
   parameter int BYTE_COUNT_WIDTH = jmsc_pkg::BYTE_COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  jmsc_pkg::queue_head_type          head,
   output logic                              pop,
   input  logic [jmsc_pkg::BUDGET_WIDTH-1:0] byte_budget,
   jmsc_rsp_if.source                        rsp_bus
);
   import jmsc_pkg::*;

   localparam int CMP_W = (BYTE_COUNT_WIDTH > BUDGET_WIDTH) ? BYTE_COUNT_WIDTH : BUDGET_WIDTH;

   parse_phase_type             phase_ff, phase_in;
   logic [15:0]                 seg_len_ff, seg_len_in;
   logic [15:0]                 skip_ff, skip_in;
   logic [2:0]                  hdr_pos_ff, hdr_pos_in;
   logic [15:0]                 width_ff, width_in;
   logic [15:0]                 height_ff, height_in;
   logic                        dims_seen_ff, dims_seen_in;
   logic                        is_scan_ff, is_scan_in;
   logic                        rejected_ff, rejected_in;
   logic [BYTE_COUNT_WIDTH-1:0] count_ff, count_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        verdict_ff, verdict_in;
   logic [15:0]                 out_width_ff, out_width_in;
   logic [15:0]                 out_height_ff, out_height_in;

   logic                        out_free;
   logic                        take_end;
   logic                        take_data;
   logic                        budget_hit;
   logic                        result_ok;
   logic [7:0]                  b;
   byte_class_type              bc;
   logic [15:0]                 full_len;
   logic [15:0]                 skip_dec;

   // Marker decision, shared by the marker and entropy phases.
   parse_phase_type             mk_phase;
   logic                        mk_reject;
   logic                        mk_set_scan;
   logic                        mk_scan;

   // End-of-segment decision.
   parse_phase_type             fin_phase;
   logic                        fin_reject;

   assign b  = head.item.data_byte;
   assign bc = head.item.byte_class;

   // An end item waits until the result register is free.
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign pop       = head.valid && ((head.item.kind == KIND_DATA) || out_free);
   assign take_end  = pop && (head.item.kind == KIND_END);
   assign take_data = pop && (head.item.kind == KIND_DATA);

   assign budget_hit = (CMP_W'(count_ff) >= CMP_W'(byte_budget)) || (&count_ff);
   assign result_ok  = !rejected_ff && ((phase_ff == PH_ACCEPTED) || (phase_ff == PH_EOI_TAIL));
   assign full_len   = {seg_len_ff[15:8], b};
   assign skip_dec   = skip_ff - 16'd1;

   // Marker code handling.
   always_comb begin
      mk_phase    = phase_ff;
      mk_reject   = 1'b0;
      mk_set_scan = 1'b0;
      mk_scan     = 1'b0;
      unique case (bc)
         BC_ZERO, BC_SOI, BC_RST: mk_reject = 1'b1;
         BC_EOI: begin
            if (!dims_seen_ff) mk_reject = 1'b1;
            else mk_phase = PH_EOI_TAIL;
         end
         BC_TEM: mk_phase = PH_PREFIX;
         BC_SOF: begin
            mk_set_scan = 1'b1;
            mk_phase    = PH_SOF_LEN_HI;
         end
         BC_SOS: begin
            mk_set_scan = 1'b1;
            mk_scan     = 1'b1;
            mk_phase    = PH_LEN_HI;
         end
         default: begin
            mk_set_scan = 1'b1;
            mk_phase    = PH_LEN_HI;
         end
      endcase
   end

   // A finished segment leads to entropy data after a scan header.
   always_comb begin
      fin_reject = is_scan_ff && !dims_seen_ff;
      fin_phase  = is_scan_ff ? (dims_seen_ff ? PH_ENTROPY : phase_ff) : PH_PREFIX;
   end

   // Parser next state.
   always_comb begin
      phase_in     = phase_ff;
      seg_len_in   = seg_len_ff;
      skip_in      = skip_ff;
      hdr_pos_in   = hdr_pos_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      dims_seen_in = dims_seen_ff;
      is_scan_in   = is_scan_ff;
      rejected_in  = rejected_ff;
      count_in     = count_ff;

      if (take_end) begin
         phase_in     = PH_SOI0;
         seg_len_in   = '0;
         skip_in      = '0;
         hdr_pos_in   = '0;
         width_in     = '0;
         height_in    = '0;
         dims_seen_in = 1'b0;
         is_scan_in   = 1'b0;
         rejected_in  = 1'b0;
         count_in     = '0;
      end else if (take_data && !rejected_ff && (phase_ff != PH_ACCEPTED)) begin
         if (budget_hit) begin
            // The budget is spent: this byte acts as end of file.
            if (phase_ff == PH_EOI_TAIL) phase_in = PH_ACCEPTED;
            else rejected_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            unique case (phase_ff)
               PH_SOI0: begin
                  if (b != CODE_FILL) rejected_in = 1'b1;
                  else phase_in = PH_SOI1;
               end
               PH_SOI1: begin
                  if (b != CODE_SOI) rejected_in = 1'b1;
                  else phase_in = PH_PREFIX;
               end
               PH_PREFIX: begin
                  if (b != CODE_FILL) rejected_in = 1'b1;
                  else phase_in = PH_MARKER;
               end
               PH_MARKER: begin
                  if (bc != BC_FILL) begin
                     phase_in    = mk_phase;
                     rejected_in = mk_reject;
                     if (mk_set_scan) is_scan_in = mk_scan;
                  end
               end
               PH_LEN_HI: begin
                  seg_len_in = {b, 8'h00};
                  phase_in   = PH_LEN_LO;
               end
               PH_SOF_LEN_HI: begin
                  seg_len_in = {b, 8'h00};
                  phase_in   = PH_SOF_LEN_LO;
               end
               PH_LEN_LO: begin
                  seg_len_in = full_len;
                  if (full_len < MIN_SEG_LEN) begin
                     rejected_in = 1'b1;
                  end else if (full_len == MIN_SEG_LEN) begin
                     skip_in     = '0;
                     phase_in    = fin_phase;
                     rejected_in = fin_reject;
                  end else begin
                     skip_in  = full_len - MIN_SEG_LEN;
                     phase_in = PH_SKIP;
                  end
               end
               PH_SOF_LEN_LO: begin
                  seg_len_in = full_len;
                  if (full_len < MIN_SOF_LEN) begin
                     rejected_in = 1'b1;
                  end else begin
                     hdr_pos_in = '0;
                     phase_in   = PH_SOF_HDR;
                  end
               end
               PH_SOF_HDR: begin
                  case (hdr_pos_ff)
                     3'd1:    height_in = {b, 8'h00};
                     3'd2:    height_in = {height_ff[15:8], b};
                     3'd3:    width_in  = {b, 8'h00};
                     3'd4:    width_in  = {width_ff[15:8], b};
                     default: ;
                  endcase
                  if (hdr_pos_ff >= HDR_LAST) begin
                     hdr_pos_in = '0;
                     if ((width_ff == '0) || (height_ff == '0) || dims_seen_ff) begin
                        rejected_in = 1'b1;
                     end else begin
                        dims_seen_in = 1'b1;
                        skip_in      = seg_len_ff - MIN_SOF_LEN;
                        if (seg_len_ff == MIN_SOF_LEN) begin
                           phase_in    = fin_phase;
                           rejected_in = fin_reject;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                  end else begin
                     hdr_pos_in = hdr_pos_ff + 3'd1;
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_dec == '0) begin
                     phase_in    = fin_phase;
                     rejected_in = fin_reject;
                  end
               end
               PH_ENTROPY: begin
                  if (bc == BC_FILL) phase_in = PH_ENTROPY_FF;
               end
               PH_ENTROPY_FF: begin
                  if ((bc == BC_ZERO) || (bc == BC_RST)) begin
                     phase_in = PH_ENTROPY;
                  end else if (bc != BC_FILL) begin
                     phase_in    = mk_phase;
                     rejected_in = mk_reject;
                     if (mk_set_scan) is_scan_in = mk_scan;
                  end
               end
               default: rejected_in = 1'b1;
            endcase
         end
      end
   end

   // Result register: loaded by an end item, emptied by the sink.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      verdict_in    = verdict_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take_end) begin
         rsp_valid_in  = 1'b1;
         verdict_in    = result_ok ? VERDICT_ACCEPT : VERDICT_REJECT;
         out_width_in  = result_ok ? width_ff : '0;
         out_height_in = result_ok ? height_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SOI0;
         seg_len_ff   <= '0;
         skip_ff      <= '0;
         hdr_pos_ff   <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         dims_seen_ff <= 1'b0;
         is_scan_ff   <= 1'b0;
         rejected_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seg_len_ff   <= seg_len_in;
         skip_ff      <= skip_in;
         hdr_pos_ff   <= hdr_pos_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         dims_seen_ff <= dims_seen_in;
         is_scan_ff   <= is_scan_in;
         rejected_ff  <= rejected_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      verdict_ff    <= verdict_in;
      out_width_ff  <= out_width_in;
      out_height_ff <= out_height_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.verdict      = verdict_ff;
   assign rsp_bus.image_width  = out_width_ff;
   assign rsp_bus.image_height = out_height_ff;

endmodule : jmsc_back

`default_nettype wire

// File: rtl/jpeg_marker_structure_checker_unit.sv
// Top level of the JPEG marker structure checker.
`default_nettype none

// Checks the marker structure of a JPEG file presented one byte per transaction on
// req_bus and closed by an end item (kind = 1). Each end item yields exactly one
// result on rsp_bus: verdict 0 with the frame width and height when the file is
// well formed (SOI, valid segments, one frame header, EOI directly before the end),
// verdict 1 with zero dimensions otherwise; data bytes yield no result. The block
// takes one item per clock cycle in sustained operation; an end item is held only
// while the previous result is still waiting in the output register. A byte that is
// accepted is registered in a queue of QUEUE_DEPTH entries before the parser takes
// it, and the result of an end item is loaded into the output register on rsp_bus
// as the parser takes that item. The csr_bus write sets the byte budget
// (reset 67108864): once that many bytes of a file are consumed, the next data byte
// counts as end of file. Write it only while the block is idle.
module jpeg_marker_structure_checker_unit #(
   parameter int BYTE_COUNT_WIDTH = jmsc_pkg::BYTE_COUNT_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH      = jmsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   jmsc_req_if.sink    req_bus,
   jmsc_rsp_if.source  rsp_bus,
   jmsc_csr_if.sink    csr_bus
);
   import jmsc_pkg::*;

   logic [BUDGET_WIDTH-1:0] budget_ff, budget_in;
   logic                    push_valid;
   logic                    push_ready;
   queue_item_type          push_item;
   queue_head_type          head;
   logic                    pop;

   // Budget register, always ready for a write.
   assign csr_bus.ready = 1'b1;
   assign budget_in     = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else begin
         budget_ff <= budget_in;
      end
   end

   jmsc_front u_front (
      .req_bus    (req_bus),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   jmsc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head)
   );

   jmsc_back #(
      .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .byte_budget (budget_ff),
      .rsp_bus     (rsp_bus)
   );

`ifndef SYNTHESIS
   // A rejected file reports zero dimensions.
   a_reject_zero_dims: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.verdict == VERDICT_REJECT)) |->
         ((rsp_bus.image_width == '0) && (rsp_bus.image_height == '0)))
      else $error("rejected result carries nonzero dimensions");

   // An accepted file always has a nonzero frame size.
   a_accept_nonzero_dims: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.verdict == VERDICT_ACCEPT)) |->
         ((rsp_bus.image_width != '0) && (rsp_bus.image_height != '0)))
      else $error("accepted result carries a zero dimension");

   // The parser only takes items that the queue holds.
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("parser popped an empty queue");

   // An end item taken by the parser puts a result on rsp_bus at the next edge.
   a_end_item_after_free: assert property (@(posedge clock) disable iff (reset)
      (pop && (head.item.kind == KIND_END)) |=> rsp_bus.valid)
      else $error("end item taken without producing a result");
`endif

endmodule : jpeg_marker_structure_checker_unit

`default_nettype wire
